// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/smc3_pkg.sv -----
package smc3_pkg;

    localparam int PIX_W     = 8;
    localparam int NUM_MASKS = 6;
    localparam int WIN_DIM   = 3;
    localparam int WIN_TAPS  = WIN_DIM * WIN_DIM;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 12;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    typedef enum logic [2:0] {
        REG_WIDTH       = 3'd0,
        REG_HEIGHT      = 3'd1,
        REG_VERTICAL    = 3'd2,
        REG_HORIZONTAL  = 3'd3,
        REG_DIAG_RISING = 3'd4,
        REG_DIAG_FALL   = 3'd5,
        REG_CROSS       = 3'd6,
        REG_RING        = 3'd7
    } t_reg_idx;

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd256;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 12'd256;
    localparam logic [WIN_TAPS-1:0] RST_MASK [NUM_MASKS] = '{
        9'd146, 9'd56, 9'd84, 9'd273, 9'd341, 9'd170
    };

    typedef logic [WIN_TAPS-1:0] t_masks [NUM_MASKS];
    typedef logic [PIX_W-1:0]    t_sums  [NUM_MASKS];

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } t_dims;

endpackage

// ----- hdl/six_mask_3x3_convolver.sv -----
// Channel   Valid     Ready     Word
// input     i_valid   o_ready   i_pixel, i_frame_start
// output    o_valid   i_ready   o_sum_*, o_last_of_frame
// config    APB       pready    paddr, pwdata, prdata
//
// One pixel per clock unless stalled; results are registered after the window stage.
// Line stores are read at acceptance and written as the pixel leaves the window stage.
// Synchronous active-low reset clears counters, window and valid flags; no clearing pass.
// A held result stalls the window stage, which stalls the input combinationally.
module six_mask_3x3_convolver
    import smc3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [PIX_W-1:0]  i_pixel,
    input  logic              i_frame_start,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [PIX_W-1:0]  o_sum_vertical,
    output logic [PIX_W-1:0]  o_sum_horizontal,
    output logic [PIX_W-1:0]  o_sum_diag_rising,
    output logic [PIX_W-1:0]  o_sum_diag_falling,
    output logic [PIX_W-1:0]  o_sum_cross,
    output logic [PIX_W-1:0]  o_sum_ring,
    output logic              o_last_of_frame,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

`include "assert_macros.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

    t_dims  dims;
    t_masks masks;
    t_sums  sums;

    logic [WW-1:0]       w_ext;
    logic [WW-1:0]       used_w;
    logic [HEIGHT_W-1:0] used_h;
    logic [CW-1:0]       col_cur;
    logic [HEIGHT_W-1:0] row_cur;
    logic [WW-1:0]       col_inc;
    logic [HEIGHT_W:0]   row_inc;
    logic                col_wrap;
    logic                in_acc;
    logic                s1_adv;
    logic                emit;
    logic                last;
    logic [PIX_W-1:0]    one_up;
    logic [PIX_W-1:0]    two_up;

    logic [CW-1:0]       r_col;
    logic [CW-1:0]       n_col;
    logic [HEIGHT_W-1:0] r_row;
    logic [HEIGHT_W-1:0] n_row;
    logic                r_s1_vld;
    logic [PIX_W-1:0]    r_s1_px;
    logic [CW-1:0]       r_s1_col;
    logic                r_s1_emit;
    logic                r_s1_last;
    logic                r_o_vld;
    t_sums               r_o_sums;
    logic                r_o_last;

    smc3_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_dims  (dims),
        .o_masks (masks)
    );

    always_comb begin
        w_ext = WW'(dims.width);
        if (w_ext < WW'(WIN_DIM)) begin
            used_w = WW'(WIN_DIM);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            used_w = WW'(MAX_WIDTH);
        end else begin
            used_w = w_ext;
        end
        if (dims.height < HEIGHT_W'(WIN_DIM)) begin
            used_h = HEIGHT_W'(WIN_DIM);
        end else begin
            used_h = dims.height;
        end
    end

    assign col_cur  = i_frame_start ? '0 : r_col;
    assign row_cur  = i_frame_start ? '0 : r_row;
    assign col_inc  = WW'(col_cur) + WW'(1);
    assign row_inc  = (HEIGHT_W + 1)'(row_cur) + (HEIGHT_W + 1)'(1);
    assign col_wrap = col_inc >= used_w;
    assign n_col    = col_wrap ? '0 : col_inc[CW-1:0];

    always_comb begin
        n_row = row_cur;
        if (col_wrap) begin
            n_row = (row_inc >= (HEIGHT_W + 1)'(used_h)) ? '0 : row_inc[HEIGHT_W-1:0];
        end
    end

    assign emit = (row_cur >= HEIGHT_W'(WIN_DIM - 1)) && (col_cur >= CW'(WIN_DIM - 1));
    assign last = (row_cur == used_h - HEIGHT_W'(1)) && (WW'(col_cur) == used_w - WW'(1));

    assign s1_adv  = r_s1_vld && (!r_o_vld || i_ready);
    assign o_ready = !r_s1_vld || s1_adv;
    assign in_acc  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_px   <= i_pixel;
            r_s1_col  <= col_cur;
            r_s1_emit <= emit;
            r_s1_last <= last;
        end
    end

    smc3_linebuf #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (col_cur),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_px   (r_s1_px),
        .i_wr_up   (one_up),
        .o_one_up  (one_up),
        .o_two_up  (two_up)
    );

    smc3_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (s1_adv),
        .i_px     (r_s1_px),
        .i_one_up (one_up),
        .i_two_up (two_up),
        .i_masks  (masks),
        .o_sums   (sums)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_adv && r_s1_emit) begin
            r_o_vld <= 1'b1;
        end else if (i_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_o_sums <= sums;
            r_o_last <= r_s1_last;
        end
    end

    assign o_valid            = r_o_vld;
    assign o_sum_vertical     = r_o_sums[0];
    assign o_sum_horizontal   = r_o_sums[1];
    assign o_sum_diag_rising  = r_o_sums[2];
    assign o_sum_diag_falling = r_o_sums[3];
    assign o_sum_cross        = r_o_sums[4];
    assign o_sum_ring         = r_o_sums[5];
    assign o_last_of_frame    = r_o_last;

    `ASSERT_NEXT(a_acc_fills_stage, i_clk, i_rst_n, in_acc, r_s1_vld)
    `ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_s1_vld && !s1_adv,
                 r_s1_vld && $stable(r_s1_col) && $stable(r_s1_px))
    `ASSERT_NEXT(a_emit_loads_out, i_clk, i_rst_n, s1_adv && r_s1_emit, r_o_vld)
    `ASSERT_SAME(a_last_emits, i_clk, i_rst_n, r_s1_vld && r_s1_last, r_s1_emit)

endmodule

// ----- hdl/smc3_cfg.sv -----
module smc3_cfg
    import smc3_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_dims             o_dims,
    output t_masks            o_masks
);

    t_dims    r_dims;
    t_masks   r_masks;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.width  <= RST_WIDTH;
            r_dims.height <= RST_HEIGHT;
            r_masks       <= RST_MASK;
        end else if (wr) begin
            case (idx)
                REG_WIDTH:       r_dims.width  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT:      r_dims.height <= pwdata[HEIGHT_W-1:0];
                REG_VERTICAL:    r_masks[0]    <= pwdata[WIN_TAPS-1:0];
                REG_HORIZONTAL:  r_masks[1]    <= pwdata[WIN_TAPS-1:0];
                REG_DIAG_RISING: r_masks[2]    <= pwdata[WIN_TAPS-1:0];
                REG_DIAG_FALL:   r_masks[3]    <= pwdata[WIN_TAPS-1:0];
                REG_CROSS:       r_masks[4]    <= pwdata[WIN_TAPS-1:0];
                REG_RING:        r_masks[5]    <= pwdata[WIN_TAPS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_WIDTH:       prdata = DATA_W'(r_dims.width);
            REG_HEIGHT:      prdata = DATA_W'(r_dims.height);
            REG_VERTICAL:    prdata = DATA_W'(r_masks[0]);
            REG_HORIZONTAL:  prdata = DATA_W'(r_masks[1]);
            REG_DIAG_RISING: prdata = DATA_W'(r_masks[2]);
            REG_DIAG_FALL:   prdata = DATA_W'(r_masks[3]);
            REG_CROSS:       prdata = DATA_W'(r_masks[4]);
            REG_RING:        prdata = DATA_W'(r_masks[5]);
            default:         prdata = '0;
        endcase
    end

    assign o_dims  = r_dims;
    assign o_masks = r_masks;

endmodule

// ----- hdl/smc3_linebuf.sv -----
module smc3_linebuf
    import smc3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [CW-1:0]    i_rd_addr,
    input  logic             i_wr_en,
    input  logic [CW-1:0]    i_wr_addr,
    input  logic [PIX_W-1:0] i_wr_px,
    input  logic [PIX_W-1:0] i_wr_up,
    output logic [PIX_W-1:0] o_one_up,
    output logic [PIX_W-1:0] o_two_up
);

    logic [PIX_W-1:0] mem_one [MAX_WIDTH];
    logic [PIX_W-1:0] mem_two [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_one;
    logic [PIX_W-1:0] r_rd_two;
    logic [PIX_W-1:0] r_byp_one;
    logic [PIX_W-1:0] r_byp_two;
    logic             r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_one[i_wr_addr] <= i_wr_px;
            mem_two[i_wr_addr] <= i_wr_up;
        end
        if (i_rd_en) begin
            r_rd_one <= mem_one[i_rd_addr];
            r_rd_two <= mem_two[i_rd_addr];
        end
    end

    // forward the word being written at the same edge
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp     <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_byp_one <= i_wr_px;
            r_byp_two <= i_wr_up;
        end
    end

    assign o_one_up = r_byp ? r_byp_one : r_rd_one;
    assign o_two_up = r_byp ? r_byp_two : r_rd_two;

endmodule

// ----- hdl/smc3_window.sv -----
module smc3_window
    import smc3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [PIX_W-1:0] i_px,
    input  logic [PIX_W-1:0] i_one_up,
    input  logic [PIX_W-1:0] i_two_up,
    input  t_masks           i_masks,
    output t_sums            o_sums
);

    logic [PIX_W-1:0] r_cols [2*WIN_DIM];
    logic [PIX_W-1:0] win    [WIN_TAPS];

    always_comb begin
        for (int k = 0; k < WIN_DIM; k++) begin
            win[k*WIN_DIM]     = r_cols[k];
            win[k*WIN_DIM + 1] = r_cols[WIN_DIM + k];
        end
        win[2] = i_two_up;
        win[5] = i_one_up;
        win[8] = i_px;
    end

    always_comb begin
        for (int m = 0; m < NUM_MASKS; m++) begin
            o_sums[m] = '0;
            for (int b = 0; b < WIN_TAPS; b++) begin
                if (i_masks[m][b]) begin
                    o_sums[m] = o_sums[m] + win[b];
                end
            end
        end
    end

    // advance the window one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2*WIN_DIM; k++) begin
                r_cols[k] <= '0;
            end
        end else if (i_adv) begin
            for (int k = 0; k < WIN_DIM; k++) begin
                r_cols[k]           <= r_cols[WIN_DIM + k];
                r_cols[WIN_DIM + k] <= win[k*WIN_DIM + 2];
            end
        end
    end

endmodule
